// ----- rtl/piecewise_bezier_evaluator_unit_macros.svh -----
// assertion helper macros for the piecewise bezier evaluator
// used by the top level; expects clk and rst_n in scope
`ifndef PIECEWISE_BEZIER_EVALUATOR_UNIT_MACROS_SVH
`define PIECEWISE_BEZIER_EVALUATOR_UNIT_MACROS_SVH

// property checked on every clock outside reset
`define PBE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never hold
`define PBE_NEVER(lbl, cond, msg) \
  `PBE_ASSERT(lbl, !(cond), msg)

`endif

// ----- rtl/pbe_pkg.sv -----
// shared types and constants for the piecewise bezier evaluator
// no dependencies
`default_nettype none
package pbe_pkg;

  localparam int MAX_SEGMENTS = 32;
  localparam int MAX_ORDER    = 7;
  localparam int POINT_DEPTH  = 256;

  localparam int SEG_IDX_W = $clog2(MAX_SEGMENTS);
  localparam int PT_IDX_W  = $clog2(POINT_DEPTH);
  localparam int QN        = MAX_ORDER + 1;
  localparam int KCNT_W    = $clog2(MAX_ORDER + 2);
  localparam int ASUM_W    = SEG_IDX_W + 4 + 10;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [1:0] CMD_POINT = 2'd0;
  localparam logic [1:0] CMD_SPAN  = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;
  localparam logic [1:0] CMD_NONE  = 2'd3;

  localparam logic [1:0] REG_ORDER = 2'd0;
  localparam logic [1:0] REG_SEGS  = 2'd1;
  localparam logic [1:0] REG_PTS   = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  slot;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
  } pbe_item_t;

  typedef struct packed {
    logic [2:0] order;
    logic [5:0] n_seg;
    logic [8:0] n_pts;
  } pbe_cfg_t;

endpackage
`default_nettype wire

// ----- rtl/pbe_front.sv -----
// front end: decodes input transactions into queue items
// depends on pbe_pkg
`default_nettype none
module pbe_front (
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [1:0]       in_tuser,
  input  wire logic [167:0]     in_tdata,
  output logic                  push_valid,
  input  wire logic             push_ready,
  output pbe_pkg::pbe_item_t    push_item
);
  import pbe_pkg::*;

  logic [31:0] qt;

  assign qt         = in_tdata[167:136];
  assign in_tready  = push_ready;
  assign push_valid = in_tvalid && (in_tuser != CMD_NONE);

  always_comb begin
    push_item.kind = in_tuser;
    push_item.slot = in_tdata[7:0];
    push_item.a    = in_tdata[39:8];
    push_item.b    = in_tdata[71:40];
    push_item.c    = in_tdata[103:72];
    if (in_tuser == CMD_SPAN) begin
      push_item.a = in_tdata[135:104];
    end else if (in_tuser == CMD_QUERY) begin
      // negative time counts as zero
      push_item.a = qt[31] ? 32'd0 : qt;
    end
  end
endmodule
`default_nettype wire

// ----- rtl/pbe_queue.sv -----
// small fifo between front and back
// depends on pbe_pkg
`default_nettype none
module pbe_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push_valid,
  output logic                  push_ready,
  input  wire pbe_pkg::pbe_item_t push_item,
  output logic                  pop_valid,
  input  wire logic             pop,
  output pbe_pkg::pbe_item_t    pop_item
);
  import pbe_pkg::*;

  pbe_item_t         mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wp_r, rp_r;
  logic [QPTR_W:0]   cnt_r;
  logic              do_push, do_pop;

  assign push_ready = (cnt_r != (QPTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_item   = mem_r[rp_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (wp_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= (rp_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
    end
  end
endmodule
`default_nettype wire

// ----- rtl/pbe_back.sv -----
// back end: stores, segment scan, division, point fetch and de casteljau
// depends on pbe_pkg
`default_nettype none
module pbe_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire pbe_pkg::pbe_cfg_t  cfg,
  input  wire logic               q_valid,
  input  wire pbe_pkg::pbe_item_t q_item,
  output logic                    q_pop,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic                    out_pv,
  output logic [127:0]            out_data
);
  import pbe_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCANW = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_FETCH = 3'd4;
  localparam logic [2:0] ST_MUL   = 3'd5;
  localparam logic [2:0] ST_ADD   = 3'd6;
  localparam logic [2:0] ST_OUT   = 3'd7;

  logic [95:0] pt_mem [POINT_DEPTH];
  logic [31:0] dur_mem [MAX_SEGMENTS];
  logic [95:0] pt_rd_r;
  logic [31:0] dur_rd_r;

  logic [2:0]           st_r, st_nxt;
  logic [SEG_IDX_W-1:0] ra_r, ra_nxt;
  logic [5:0]           i_r, i_nxt;
  logic                 found_r, found_nxt;
  logic [SEG_IDX_W-1:0] seg_r, seg_nxt;
  logic [31:0]          t_r, t_nxt;
  logic [31:0]          dsel_r, dsel_nxt;
  logic [31:0]          total_r, total_nxt;
  logic [31:0]          rem_r, rem_nxt;
  logic [15:0]          quot_r, quot_nxt;
  logic [3:0]           dcnt_r, dcnt_nxt;
  logic [16:0]          s_r, s_nxt;
  logic [KCNT_W-1:0]    fc_r, fc_nxt;
  logic [KCNT_W-1:0]    sz_r, sz_nxt;
  logic [KCNT_W-1:0]    j_r, j_nxt;
  logic                 rv_r, rv_nxt;
  logic signed [31:0]   q_r [3][QN];
  logic signed [31:0]   q_nxt [3][QN];
  logic signed [50:0]   prod_r [3];
  logic signed [50:0]   prod_nxt [3];
  logic                 ov_r;
  logic                 opv_r;
  logic [127:0]         od_r;

  logic                 qry_ok, last_i, take, last_lerp, out_ld;
  logic [32:0]          sum33, r2;
  logic [31:0]          tm;
  logic [ASUM_W-1:0]    asum, npm1;
  logic [PT_IDX_W-1:0]  pa;
  logic [KCNT_W-1:0]    ordk, sz_m1, sz_m2, fc_m1;
  logic signed [31:0]   res [3];
  logic                 pt_we, dur_we;

  assign qry_ok = (cfg.n_seg != '0) && (cfg.n_pts != '0) && (cfg.order != '0);
  assign last_i = (i_r == cfg.n_seg - 6'd1);
  assign ordk   = KCNT_W'(cfg.order);
  assign sz_m1  = sz_r - 1'b1;
  assign sz_m2  = sz_r - KCNT_W'(2);
  assign fc_m1  = fc_r - 1'b1;
  assign last_lerp = (j_r == sz_m2);
  assign sum33  = {1'b0, total_r} + {1'b0, dur_rd_r};
  assign take   = !found_r && ((t_r <= dur_rd_r) || last_i);
  assign tm     = t_r - dur_rd_r;
  assign r2     = {rem_r, 1'b0};
  assign npm1   = ASUM_W'(cfg.n_pts) - 1'b1;
  assign asum   = ASUM_W'(seg_r) * ASUM_W'(cfg.order) + ASUM_W'(fc_r);
  assign pa     = (asum > npm1) ? npm1[PT_IDX_W-1:0] : asum[PT_IDX_W-1:0];
  assign out_ld = (st_r == ST_OUT) && (!ov_r || out_tready);

  assign pt_we  = (st_r == ST_IDLE) && q_valid && (q_item.kind == CMD_POINT)
                  && (32'(q_item.slot) < 32'(POINT_DEPTH));
  assign dur_we = (st_r == ST_IDLE) && q_valid && (q_item.kind == CMD_SPAN)
                  && (32'(q_item.slot) < 32'(MAX_SEGMENTS));
  assign q_pop  = (st_r == ST_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (pt_we) begin
      pt_mem[q_item.slot[PT_IDX_W-1:0]] <= {q_item.c, q_item.b, q_item.a};
    end
    if (dur_we) begin
      dur_mem[q_item.slot[SEG_IDX_W-1:0]] <= q_item.a;
    end
    pt_rd_r  <= pt_mem[pa];
    dur_rd_r <= dur_mem[ra_r];
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      res[a] = q_r[a][0] + prod_r[a][47:16];
    end
  end

  always_comb begin
    st_nxt    = st_r;
    ra_nxt    = ra_r;
    i_nxt     = i_r;
    found_nxt = found_r;
    seg_nxt   = seg_r;
    t_nxt     = t_r;
    dsel_nxt  = dsel_r;
    total_nxt = total_r;
    rem_nxt   = rem_r;
    quot_nxt  = quot_r;
    dcnt_nxt  = dcnt_r;
    s_nxt     = s_r;
    fc_nxt    = fc_r;
    sz_nxt    = sz_r;
    j_nxt     = j_r;
    rv_nxt    = rv_r;
    for (int a = 0; a < 3; a++) begin
      prod_nxt[a] = prod_r[a];
      for (int i = 0; i < QN; i++) begin
        q_nxt[a][i] = q_r[a][i];
      end
    end
    case (st_r)
      ST_IDLE: begin
        if (q_valid && (q_item.kind == CMD_QUERY)) begin
          t_nxt     = q_item.a;
          total_nxt = '0;
          rv_nxt    = 1'b0;
          found_nxt = 1'b0;
          ra_nxt    = '0;
          i_nxt     = '0;
          st_nxt    = (cfg.n_seg == '0) ? ST_OUT : ST_SCANW;
        end
      end
      ST_SCANW: begin
        ra_nxt = ra_r + 1'b1;
        st_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        ra_nxt    = ra_r + 1'b1;
        i_nxt     = i_r + 1'b1;
        total_nxt = sum33[32] ? '1 : sum33[31:0];
        if (take) begin
          found_nxt = 1'b1;
          seg_nxt   = i_r[SEG_IDX_W-1:0];
          dsel_nxt  = dur_rd_r;
        end else if (!found_r) begin
          t_nxt = tm;
        end
        if (last_i) begin
          if (!qry_ok) begin
            st_nxt = ST_OUT;
          end else begin
            st_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (found_r && (dcnt_r == '0) && ((dsel_r == '0) || (t_r >= dsel_r))) begin
          s_nxt  = 17'h10000;
          fc_nxt = '0;
          st_nxt = ST_FETCH;
        end else begin
          if (found_r) begin
            rem_nxt = t_r;
            found_nxt = 1'b0;
          end else begin
            if (r2 >= {1'b0, dsel_r}) begin
              rem_nxt  = 32'(r2 - {1'b0, dsel_r});
              quot_nxt = {quot_r[14:0], 1'b1};
            end else begin
              rem_nxt  = r2[31:0];
              quot_nxt = {quot_r[14:0], 1'b0};
            end
            dcnt_nxt = dcnt_r + 1'b1;
            if (dcnt_r == 4'd15) begin
              s_nxt  = {1'b0, quot_nxt};
              fc_nxt = '0;
              st_nxt = ST_FETCH;
            end
          end
        end
      end
      ST_FETCH: begin
        fc_nxt = fc_r + 1'b1;
        if (fc_r != '0) begin
          for (int i = 0; i < QN; i++) begin
            if (KCNT_W'(i) == fc_m1) begin
              q_nxt[0][i] = pt_rd_r[31:0];
              q_nxt[1][i] = pt_rd_r[63:32];
              q_nxt[2][i] = pt_rd_r[95:64];
            end
          end
        end
        if (fc_r == ordk + 1'b1) begin
          sz_nxt = ordk + 1'b1;
          j_nxt  = '0;
          st_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        for (int a = 0; a < 3; a++) begin
          prod_nxt[a] = ($signed({q_r[a][1][31], q_r[a][1]})
                         - $signed({q_r[a][0][31], q_r[a][0]}))
                        * $signed({1'b0, s_r});
        end
        st_nxt = ST_ADD;
      end
      ST_ADD: begin
        for (int a = 0; a < 3; a++) begin
          for (int i = 0; i < QN; i++) begin
            if (last_lerp) begin
              if (KCNT_W'(i) == sz_m2) begin
                q_nxt[a][i] = res[a];
              end else if (i + 2 < QN) begin
                q_nxt[a][i] = q_r[a][(i + 2) % QN];
              end
            end else begin
              if (KCNT_W'(i) == sz_m1) begin
                q_nxt[a][i] = res[a];
              end else if (i + 1 < QN) begin
                q_nxt[a][i] = q_r[a][(i + 1) % QN];
              end
            end
          end
        end
        if (last_lerp) begin
          sz_nxt = sz_m1;
          j_nxt  = '0;
          if (sz_r == KCNT_W'(2)) begin
            rv_nxt = 1'b1;
            st_nxt = ST_OUT;
          end else begin
            st_nxt = ST_MUL;
          end
        end else begin
          j_nxt  = j_r + 1'b1;
          st_nxt = ST_MUL;
        end
      end
      ST_OUT: begin
        if (out_ld) begin
          st_nxt = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (out_ld) begin
        ov_r <= 1'b1;
      end else if (out_tready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ra_r    <= ra_nxt;
    i_r     <= i_nxt;
    found_r <= found_nxt;
    seg_r   <= seg_nxt;
    t_r     <= t_nxt;
    dsel_r  <= dsel_nxt;
    total_r <= total_nxt;
    rem_r   <= rem_nxt;
    quot_r  <= (st_r == ST_SCAN) ? '0 : quot_nxt;
    dcnt_r  <= (st_r == ST_SCAN) ? '0 : dcnt_nxt;
    s_r     <= s_nxt;
    fc_r    <= fc_nxt;
    sz_r    <= sz_nxt;
    j_r     <= j_nxt;
    rv_r    <= rv_nxt;
    for (int a = 0; a < 3; a++) begin
      prod_r[a] <= prod_nxt[a];
      for (int i = 0; i < QN; i++) begin
        q_r[a][i] <= q_nxt[a][i];
      end
    end
    if (out_ld) begin
      opv_r <= rv_r;
      od_r  <= rv_r ? {total_r, q_r[2][0], q_r[1][0], q_r[0][0]}
                    : {total_r, 96'd0};
    end
  end

  assign out_tvalid = ov_r;
  assign out_pv     = opv_r;
  assign out_data   = od_r;
endmodule
`default_nettype wire

// ----- rtl/piecewise_bezier_evaluator_unit.sv -----
// load items: written by the back end when it is idle, after a two-entry queue
// query: the time from accept to result is set by the duration scan,
//   the 16-step divider (skipped when s clamps) and the lerp unit
// one item in the back end at a time; up to 2 more wait in the queue
// reset (rst_n low, synchronous) clears control, queue and config registers;
//   point and duration stores are not cleared
`default_nettype none
`include "piecewise_bezier_evaluator_unit_macros.svh"
module piecewise_bezier_evaluator_unit (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [1:0]   in_tuser,   // command
  input  wire logic [167:0] in_tdata,   // slot_index, coord_x, coord_y, coord_z,
                                        // span_ticks, query_time
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [0:0]        out_tuser,  // pos_valid
  output logic [127:0]      out_tdata,  // pos_x, pos_y, pos_z, total_ticks
  input  wire logic         cfg_wr_en,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [8:0]   cfg_data
);
  import pbe_pkg::*;

  logic [2:0] order_r;
  logic [5:0] nseg_r;
  logic [8:0] npts_r;
  pbe_cfg_t   cfg;
  logic       push_valid, push_ready, q_valid, q_pop, pv;
  pbe_item_t  push_item, q_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= '0;
      nseg_r  <= '0;
      npts_r  <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_ORDER: order_r <= cfg_data[2:0];
        REG_SEGS:  nseg_r  <= cfg_data[5:0];
        REG_PTS:   npts_r  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cfg.order = (32'(order_r) > MAX_ORDER) ? 3'(MAX_ORDER) : order_r;
    cfg.n_seg = (32'(nseg_r) > MAX_SEGMENTS) ? 6'(MAX_SEGMENTS) : nseg_r;
    cfg.n_pts = (32'(npts_r) > POINT_DEPTH) ? 9'(POINT_DEPTH) : npts_r;
  end

  pbe_front u_front (
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  pbe_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_item   (q_item)
  );

  pbe_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_pv     (pv),
    .out_data   (out_tdata)
  );

  assign out_tuser = pv;

  `PBE_ASSERT(a_invalid_zero, (out_tvalid && !out_tuser[0]) |-> (out_tdata[95:0] == 96'd0), "invalid result carries a nonzero position")
  `PBE_NEVER(a_pop_empty, q_pop && !q_valid, "back end popped an empty queue")
  `PBE_ASSERT(a_cmd_none_dropped, (in_tvalid && in_tuser == CMD_NONE) |-> !push_valid, "unused command entered the queue")
endmodule
`default_nettype wire
